[design/look_disk_request_scheduler_core_defines.svh]
// assertion macros shared by the look disk scheduler rtl
`ifndef LOOK_DISK_REQUEST_SCHEDULER_CORE_DEFINES_SVH
`define LOOK_DISK_REQUEST_SCHEDULER_CORE_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define LDRS_ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("ldrs invariant violated");

// condition in one cycle that implies a condition in the next cycle
`define LDRS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ldrs sequence violated");

`endif

[design/ldrs_pkg.sv]
// shared constants and types for the look disk request scheduler
package ldrs_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int TRK_W       = 16;
   localparam int TC_W        = 17;
   localparam int SUM_W       = 32;
   localparam int SUMX_W      = SUM_W + 1;
   localparam int MODE_W      = 2;
   localparam int DIR_W       = 2;
   localparam int PEND_W      = 5;

   localparam logic [MODE_W-1:0] MODE_ADD     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SERVE   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

   localparam logic [TC_W-1:0] TRACK_COUNT_RESET = 17'h10000;

   typedef enum logic [DIR_W-1:0] {
      DIR_IDLE = 2'd0,
      DIR_INC  = 2'd1,
      DIR_DEC  = 2'd2
   } dir_type;

   // one queue entry handed to the candidate tracker
   typedef struct packed {
      logic             clear;
      logic             vld;
      logic [IDX_W-1:0] idx;
      logic [TRK_W-1:0] trk;
   } scan_ctrl_type;

   // best candidates found so far in the open batch
   typedef struct packed {
      logic             match_found;
      logic [IDX_W-1:0] match_idx;
      logic [TRK_W-1:0] match_trk;
      logic             any_ahead;
      logic [IDX_W-1:0] idx_ahead;
      logic [TRK_W-1:0] trk_ahead;
      logic [TC_W-1:0]  near_ahead;
      logic             any_back;
      logic [IDX_W-1:0] idx_back;
      logic [TRK_W-1:0] trk_back;
      logic [TC_W-1:0]  near_back;
      logic [TRK_W-1:0] trk0;
   } scan_result_type;

endpackage

[design/ldrs_scan.sv]
// shared distance comparator and best-candidate registers for the batch scan
module ldrs_scan (
   input  logic                    clock,
   input  logic                    reset,
   input  ldrs_pkg::scan_ctrl_type ctrl,
   input  logic [ldrs_pkg::TRK_W-1:0] head_track,
   input  logic [ldrs_pkg::TC_W-1:0]  track_count,
   output ldrs_pkg::scan_result_type  result
);
   import ldrs_pkg::*;

   scan_result_type  res_ff;
   scan_result_type  res_in;
   logic             ahead;
   logic [TRK_W-1:0] trk_gap;

   always_comb begin
      ahead   = ctrl.trk > head_track;
      trk_gap = ahead ? (ctrl.trk - head_track) : (head_track - ctrl.trk);
      res_in  = res_ff;
      if (ctrl.clear) begin
         res_in.match_found = 1'b0;
         res_in.any_ahead   = 1'b0;
         res_in.any_back    = 1'b0;
         res_in.idx_ahead   = '0;
         res_in.idx_back    = '0;
         res_in.near_ahead  = track_count;
         res_in.near_back   = track_count;
      end else if (ctrl.vld) begin
         if (ctrl.idx == '0) begin
            res_in.trk0 = ctrl.trk;
         end
         // first exact hit wins, nothing after it matters
         if (!res_ff.match_found) begin
            if (ctrl.trk == head_track) begin
               res_in.match_found = 1'b1;
               res_in.match_idx   = ctrl.idx;
               res_in.match_trk   = ctrl.trk;
            end else if (ahead) begin
               if ({1'b0, trk_gap} < res_ff.near_ahead) begin
                  res_in.any_ahead  = 1'b1;
                  res_in.idx_ahead  = ctrl.idx;
                  res_in.trk_ahead  = ctrl.trk;
                  res_in.near_ahead = {1'b0, trk_gap};
               end
            end else begin
               if ({1'b0, trk_gap} < res_ff.near_back) begin
                  res_in.any_back  = 1'b1;
                  res_in.idx_back  = ctrl.idx;
                  res_in.trk_back  = ctrl.trk;
                  res_in.near_back = {1'b0, trk_gap};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= '0;
      end else begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

[design/look_disk_request_scheduler_core.sv]
// top level of the look elevator disk request scheduler
// usage:
//  - req channel (req_valid / req_stall) carries one transaction per command:
//    req_mode add, serve or restart, plus req_request_track
//  - rsp channel (rsp_valid / rsp_stall) returns exactly one transaction per
//    command with the served track, seek distance, direction and totals
//  - csr channel (csr_valid / csr_ready) writes track_count, taken while idle
// command sequence:
//  - add, restart and the unused mode: the finish step registers the result
//  - serve on an empty queue: also straight to the finish step
//  - serve: scan steps over the batch, a decide step, a read and write step
//    pair per entry behind the served one for compaction, then the finish step
//  - the scan is set by the single queue read port and the one distance
//    comparator, which walk the batch one entry per cycle
//  - req_stall stays high from accept until the result is registered
// reset: queue empty, no open batch, head at track 0, direction idle, totals 0
// rsp stall: the result register holds; the next command may be accepted and
// processed, but its result waits in the final step until the register frees
`include "look_disk_request_scheduler_core_defines.svh"

module look_disk_request_scheduler_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ldrs_pkg::MODE_W-1:0]   req_mode,
   input  logic [ldrs_pkg::TRK_W-1:0]    req_request_track,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_served_valid,
   output logic [ldrs_pkg::TRK_W-1:0]    rsp_served_track,
   output logic [ldrs_pkg::TRK_W-1:0]    rsp_seek_distance,
   output logic [ldrs_pkg::DIR_W-1:0]    rsp_head_direction,
   output logic                          rsp_add_rejected,
   output logic [ldrs_pkg::PEND_W-1:0]   rsp_pending_count,
   output logic [ldrs_pkg::SUM_W-1:0]    rsp_total_traversed,
   output logic [ldrs_pkg::SUM_W-1:0]    rsp_served_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ldrs_pkg::TC_W-1:0]     csr_track_count
);
   import ldrs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_FIN
   } state_type;

   // sequencer and architectural state
   state_type         state_ff, state_in;
   logic [MODE_W-1:0] op_ff, op_in;
   logic [TRK_W-1:0]  req_trk_ff, req_trk_in;
   logic [TC_W-1:0]   track_count_ff, track_count_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  batch_ff, batch_in;
   logic [TRK_W-1:0]  head_ff, head_in;
   dir_type           dir_ff, dir_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]  count_ff, count_in;

   // scan pipeline and chosen entry
   logic [CNT_W-1:0]  scan_cnt_ff, scan_cnt_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]  sel_idx_ff, sel_idx_in;
   logic [TRK_W-1:0]  sel_trk_ff, sel_trk_in;
   logic [TRK_W-1:0]  dist_ff, dist_in;
   logic [IDX_W-1:0]  shift_idx_ff, shift_idx_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_served_valid_ff, rsp_served_valid_in;
   logic [TRK_W-1:0]  rsp_served_track_ff, rsp_served_track_in;
   logic [TRK_W-1:0]  rsp_seek_distance_ff, rsp_seek_distance_in;
   logic [DIR_W-1:0]  rsp_head_direction_ff, rsp_head_direction_in;
   logic              rsp_add_rejected_ff, rsp_add_rejected_in;
   logic [PEND_W-1:0] rsp_pending_count_ff, rsp_pending_count_in;
   logic [SUM_W-1:0]  rsp_total_ff, rsp_total_in;
   logic [SUM_W-1:0]  rsp_count_ff, rsp_count_in;

   // queue memory, one write and one registered read per cycle
   logic [TRK_W-1:0]  queue_mem [QUEUE_DEPTH];
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [TRK_W-1:0]  mem_wdata;
   logic [IDX_W-1:0]  rd_addr;
   logic [TRK_W-1:0]  rd_data_ff;

   scan_ctrl_type     scan_ctrl;
   scan_result_type   scan_res;

   logic              accept;
   logic              out_free;
   logic              add_reject;
   logic [SUMX_W-1:0] sum_wide;
   logic [IDX_W-1:0]  dec_idx;
   logic [TRK_W-1:0]  dec_trk;
   dir_type           dec_dir;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   // result slot is free when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign add_reject = (len_ff >= CNT_W'(QUEUE_DEPTH)) ||
                       ({1'b0, req_trk_ff} >= track_count_ff);
   assign sum_wide   = {1'b0, sum_ff} + SUMX_W'(dist_ff);

   ldrs_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (scan_ctrl),
      .head_track  (head_ff),
      .track_count (track_count_ff),
      .result      (scan_res)
   );

   // look decision once the batch has been walked
   always_comb begin
      dec_idx = '0;
      dec_trk = scan_res.trk0;
      dec_dir = dir_ff;
      if (scan_res.match_found) begin
         // exact hit keeps the current direction, idle included
         dec_idx = scan_res.match_idx;
         dec_trk = scan_res.match_trk;
      end else begin
         case (dir_ff)
            DIR_INC: begin
               if (scan_res.any_ahead) begin
                  dec_idx = scan_res.idx_ahead;
                  dec_trk = scan_res.trk_ahead;
               end else begin
                  // nothing ahead: turn around
                  dec_dir = DIR_DEC;
                  if (scan_res.any_back) begin
                     dec_idx = scan_res.idx_back;
                     dec_trk = scan_res.trk_back;
                  end
               end
            end
            DIR_DEC: begin
               if (scan_res.any_back) begin
                  dec_idx = scan_res.idx_back;
                  dec_trk = scan_res.trk_back;
               end else begin
                  dec_dir = DIR_INC;
                  if (scan_res.any_ahead) begin
                     dec_idx = scan_res.idx_ahead;
                     dec_trk = scan_res.trk_ahead;
                  end
               end
            end
            default: begin
               // idle: nearest wins, oldest entry on a tie
               if (scan_res.any_ahead &&
                   (!scan_res.any_back ||
                    scan_res.near_ahead < scan_res.near_back ||
                    (scan_res.near_ahead == scan_res.near_back &&
                     scan_res.idx_ahead < scan_res.idx_back))) begin
                  dec_idx = scan_res.idx_ahead;
                  dec_trk = scan_res.trk_ahead;
                  dec_dir = DIR_INC;
               end else if (scan_res.any_back) begin
                  dec_idx = scan_res.idx_back;
                  dec_trk = scan_res.trk_back;
                  dec_dir = DIR_DEC;
               end else begin
                  // no candidate inside the distance bound: entry 0
                  dec_dir = DIR_IDLE;
               end
            end
         endcase
      end
   end

   // sequencer next-state logic
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      req_trk_in     = req_trk_ff;
      track_count_in = track_count_ff;
      len_in         = len_ff;
      batch_in       = batch_ff;
      head_in        = head_ff;
      dir_in         = dir_ff;
      sum_in         = sum_ff;
      count_in       = count_ff;
      scan_cnt_in    = scan_cnt_ff;
      cmp_vld_in     = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      sel_idx_in     = sel_idx_ff;
      sel_trk_in     = sel_trk_ff;
      dist_in        = dist_ff;
      shift_idx_in   = shift_idx_ff;

      rsp_valid_in          = rsp_valid_ff;
      rsp_served_valid_in   = rsp_served_valid_ff;
      rsp_served_track_in   = rsp_served_track_ff;
      rsp_seek_distance_in  = rsp_seek_distance_ff;
      rsp_head_direction_in = rsp_head_direction_ff;
      rsp_add_rejected_in   = rsp_add_rejected_ff;
      rsp_pending_count_in  = rsp_pending_count_ff;
      rsp_total_in          = rsp_total_ff;
      rsp_count_in          = rsp_count_ff;

      mem_we    = 1'b0;
      mem_waddr = len_ff[IDX_W-1:0];
      mem_wdata = req_trk_ff;
      rd_addr   = scan_cnt_ff[IDX_W-1:0];

      scan_ctrl.clear = 1'b0;
      scan_ctrl.vld   = cmp_vld_ff;
      scan_ctrl.idx   = cmp_idx_ff;
      scan_ctrl.trk   = rd_data_ff;

      // downstream took the result
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid && csr_ready) begin
         track_count_in = csr_track_count;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in      = req_mode;
               req_trk_in = req_request_track;
               if (req_mode == MODE_SERVE && len_ff != '0) begin
                  // freeze a new batch when none is open
                  if (batch_ff == '0) begin
                     batch_in = len_ff;
                  end
                  scan_cnt_in     = '0;
                  scan_ctrl.clear = 1'b1;
                  state_in        = ST_SCAN;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_SCAN: begin
            // one read issued per cycle, compared the cycle after
            if (scan_cnt_ff < batch_ff) begin
               cmp_vld_in  = 1'b1;
               cmp_idx_in  = scan_cnt_ff[IDX_W-1:0];
               scan_cnt_in = scan_cnt_ff + CNT_W'(1);
            end else if (!cmp_vld_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            sel_idx_in   = dec_idx;
            sel_trk_in   = dec_trk;
            dir_in       = dec_dir;
            dist_in      = (dec_trk > head_ff) ? (dec_trk - head_ff) : (head_ff - dec_trk);
            shift_idx_in = dec_idx;
            if (CNT_W'(dec_idx) + CNT_W'(1) < len_ff) begin
               state_in = ST_SHIFT_RD;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_SHIFT_RD: begin
            rd_addr  = shift_idx_ff + IDX_W'(1);
            state_in = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            // close the gap left by the served entry
            mem_we       = 1'b1;
            mem_waddr    = shift_idx_ff;
            mem_wdata    = rd_data_ff;
            shift_idx_in = shift_idx_ff + IDX_W'(1);
            if (CNT_W'(shift_idx_ff) + CNT_W'(2) < len_ff) begin
               state_in = ST_SHIFT_RD;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in             = ST_IDLE;
               rsp_valid_in         = 1'b1;
               rsp_served_valid_in  = 1'b0;
               rsp_seek_distance_in = '0;
               rsp_add_rejected_in  = 1'b0;
               case (op_ff)
                  MODE_ADD: begin
                     if (add_reject) begin
                        rsp_add_rejected_in = 1'b1;
                     end else begin
                        mem_we = 1'b1;
                        len_in = len_ff + CNT_W'(1);
                     end
                  end
                  MODE_SERVE: begin
                     if (len_ff != '0) begin
                        head_in = sel_trk_ff;
                        len_in  = len_ff - CNT_W'(1);
                        if (batch_ff != '0) begin
                           batch_in = batch_ff - CNT_W'(1);
                        end
                        // saturating running totals
                        sum_in = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
                        if (count_ff != '1) begin
                           count_in = count_ff + SUM_W'(1);
                        end
                        rsp_served_valid_in  = 1'b1;
                        rsp_seek_distance_in = dist_ff;
                     end
                  end
                  MODE_RESTART: begin
                     dir_in   = DIR_IDLE;
                     head_in  = req_trk_ff;
                     sum_in   = '0;
                     count_in = '0;
                  end
                  default: begin
                     // unused mode only reports status
                  end
               endcase
               rsp_served_track_in   = head_in;
               rsp_head_direction_in = dir_in;
               rsp_pending_count_in  = PEND_W'(len_in);
               rsp_total_in          = sum_in;
               rsp_count_in          = count_in;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         queue_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= queue_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         track_count_ff <= TRACK_COUNT_RESET;
         len_ff         <= '0;
         batch_ff       <= '0;
         head_ff        <= '0;
         dir_ff         <= DIR_IDLE;
         sum_ff         <= '0;
         count_ff       <= '0;
         cmp_vld_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         track_count_ff <= track_count_in;
         len_ff         <= len_in;
         batch_ff       <= batch_in;
         head_ff        <= head_in;
         dir_ff         <= dir_in;
         sum_ff         <= sum_in;
         count_ff       <= count_in;
         cmp_vld_ff     <= cmp_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      op_ff                 <= op_in;
      req_trk_ff            <= req_trk_in;
      scan_cnt_ff           <= scan_cnt_in;
      cmp_idx_ff            <= cmp_idx_in;
      sel_idx_ff            <= sel_idx_in;
      sel_trk_ff            <= sel_trk_in;
      dist_ff               <= dist_in;
      shift_idx_ff          <= shift_idx_in;
      rsp_served_valid_ff   <= rsp_served_valid_in;
      rsp_served_track_ff   <= rsp_served_track_in;
      rsp_seek_distance_ff  <= rsp_seek_distance_in;
      rsp_head_direction_ff <= rsp_head_direction_in;
      rsp_add_rejected_ff   <= rsp_add_rejected_in;
      rsp_pending_count_ff  <= rsp_pending_count_in;
      rsp_total_ff          <= rsp_total_in;
      rsp_count_ff          <= rsp_count_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_served_valid    = rsp_served_valid_ff;
   assign rsp_served_track    = rsp_served_track_ff;
   assign rsp_seek_distance   = rsp_seek_distance_ff;
   assign rsp_head_direction  = rsp_head_direction_ff;
   assign rsp_add_rejected    = rsp_add_rejected_ff;
   assign rsp_pending_count   = rsp_pending_count_ff;
   assign rsp_total_traversed = rsp_total_ff;
   assign rsp_served_count    = rsp_count_ff;

   // open batch never reaches past the queue fill
   `LDRS_ASSERT_ALWAYS(a_batch_in_queue, batch_ff <= len_ff)
   // an accepted command holds off the next one
   `LDRS_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   // the chosen entry lies inside the queue
   `LDRS_ASSERT_NEXT(a_sel_in_queue, state_ff == ST_DECIDE, CNT_W'(sel_idx_ff) < len_ff)
   // a completed serve reports a hit and drops one entry
   `LDRS_ASSERT_NEXT(a_serve_pops,
      state_ff == ST_FIN && out_free && op_ff == MODE_SERVE && len_ff != '0,
      rsp_served_valid && len_ff == $past(len_ff) - CNT_W'(1))

endmodule

[test/look_disk_request_scheduler_core_tb.sv]
// self-checking testbench for the look elevator disk request scheduler core
module look_disk_request_scheduler_core_tb;
   import ldrs_pkg::*;

   // mode code the block leaves unused; it must only report the current status
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam logic [SUM_W-1:0]  SUM_MAX     = '1;
   // cycles without any transaction on any channel before the run is declared hung
   localparam int STALL_LIMIT = 5000;
   // length of the long receiver hold-off that fills the block up
   localparam int HOLD_CYCLES = 400;
   localparam int MAX_PRINTED = 50;

   // one response as the block should return it
   typedef struct packed {
      logic             served;
      logic [TRK_W-1:0] track;
      logic [TRK_W-1:0] seek;
      dir_type          dir;
      logic             rejected;
      logic [PEND_W-1:0] pending;
      logic [SUM_W-1:0] traversed;
      logic [SUM_W-1:0] count;
   } sched_status_type;

   // directed rows: a command checked by the predictor, a command with its status
   // written out, or a track_count write
   typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      logic [MODE_W-1:0] mode;
      logic [TC_W-1:0]  value;
      sched_status_type want;
   } plan_row_type;

   localparam plan_row_type PLAN [28] = '{
      // serve on an empty queue and the unused mode right after reset
      '{ROW_TYPED, MODE_SERVE,   17'd0,     '0},
      '{ROW_TYPED, MODE_UNUSED,  17'h0abcd, '0},
      // the two track extremes
      '{ROW_TYPED, MODE_ADD,     17'd65535,
        '{1'b0, 16'd0, 16'd0, DIR_IDLE, 1'b0, 5'd1, 32'd0, 32'd0}},
      '{ROW_TYPED, MODE_ADD,     17'd0,
        '{1'b0, 16'd0, 16'd0, DIR_IDLE, 1'b0, 5'd2, 32'd0, 32'd0}},
      // exact match from idle stays idle
      '{ROW_TYPED, MODE_SERVE,   17'd0,
        '{1'b1, 16'd0, 16'd0, DIR_IDLE, 1'b0, 5'd1, 32'd0, 32'd1}},
      // longest seek
      '{ROW_TYPED, MODE_SERVE,   17'd0,
        '{1'b1, 16'd65535, 16'd65535, DIR_INC, 1'b0, 5'd0, 32'd65535, 32'd2}},
      '{ROW_TYPED, MODE_RESTART, 17'd100,
        '{1'b0, 16'd100, 16'd0, DIR_IDLE, 1'b0, 5'd0, 32'd0, 32'd0}},
      // equal distance from idle: older entry wins
      '{ROW_ITEM,  MODE_ADD,     17'd90,    '0},
      '{ROW_ITEM,  MODE_ADD,     17'd110,   '0},
      '{ROW_ITEM,  MODE_SERVE,   17'd0,     '0},
      // entry added after the batch froze is not searched; turn back
      '{ROW_ITEM,  MODE_ADD,     17'd90,    '0},
      '{ROW_ITEM,  MODE_SERVE,   17'd0,     '0},
      '{ROW_ITEM,  MODE_SERVE,   17'd0,     '0},
      // exact match while moving keeps the direction
      '{ROW_ITEM,  MODE_ADD,     17'd90,    '0},
      '{ROW_ITEM,  MODE_SERVE,   17'd0,     '0},
      '{ROW_ITEM,  MODE_RESTART, 17'd0,     '0},
      '{ROW_ITEM,  MODE_ADD,     17'd10,    '0},
      '{ROW_ITEM,  MODE_SERVE,   17'd0,     '0},
      '{ROW_ITEM,  MODE_ADD,     17'd500,   '0},
      '{ROW_ITEM,  MODE_ADD,     17'd3,     '0},
      // shrink the disk so no candidate is near enough while moving
      '{ROW_CSR,   MODE_ADD,     17'd5,     '0},
      '{ROW_ITEM,  MODE_SERVE,   17'd0,     '0},
      '{ROW_ITEM,  MODE_SERVE,   17'd0,     '0},
      // one-track disk: out of range add and no candidate from idle
      '{ROW_CSR,   MODE_ADD,     17'd1,     '0},
      '{ROW_ITEM,  MODE_ADD,     17'd0,     '0},
      '{ROW_ITEM,  MODE_ADD,     17'd1,     '0},
      '{ROW_ITEM,  MODE_RESTART, 17'd7,     '0},
      '{ROW_ITEM,  MODE_SERVE,   17'd0,     '0}
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [MODE_W-1:0]   req_mode = MODE_ADD;
   logic [TRK_W-1:0]    req_request_track = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_served_valid;
   logic [TRK_W-1:0]    rsp_served_track;
   logic [TRK_W-1:0]    rsp_seek_distance;
   logic [DIR_W-1:0]    rsp_head_direction;
   logic                rsp_add_rejected;
   logic [PEND_W-1:0]   rsp_pending_count;
   logic [SUM_W-1:0]    rsp_total_traversed;
   logic [SUM_W-1:0]    rsp_served_count;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [TC_W-1:0]     csr_track_count = TRACK_COUNT_RESET;

   // predictor state: queue, open batch, head, direction, totals and track_count
   logic [TRK_W-1:0]    queue_trk [QUEUE_DEPTH];
   int                  q_len;
   int                  batch_left;
   logic [TRK_W-1:0]    head;
   dir_type             dir_now;
   logic [SUM_W-1:0]    traversed;
   logic [SUM_W-1:0]    served_total;
   logic [TC_W-1:0]     track_limit;

   // statuses predicted for accepted commands, oldest first
   sched_status_type    status_due [$];

   int err_cnt     = 0;
   int n_items     = 0;
   int n_checked   = 0;
   int n_rejects   = 0;
   int n_serves    = 0;
   int n_csr       = 0;
   int gap_pct     = 0;
   int stall_pct   = 0;
   int hold_req    = 0;
   int stall_left  = 0;
   int idle_cycles = 0;

   look_disk_request_scheduler_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_request_track   (req_request_track),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_served_valid    (rsp_served_valid),
      .rsp_served_track    (rsp_served_track),
      .rsp_seek_distance   (rsp_seek_distance),
      .rsp_head_direction  (rsp_head_direction),
      .rsp_add_rejected    (rsp_add_rejected),
      .rsp_pending_count   (rsp_pending_count),
      .rsp_total_traversed (rsp_total_traversed),
      .rsp_served_count    (rsp_served_count),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_track_count     (csr_track_count)
   );

   always #5 clock = ~clock;

   // index of the entry the elevator serves next; updates the direction
   function automatic int choose_entry();
      int unsigned near_up;
      int unsigned near_dn;
      int          idx_up;
      int          idx_dn;
      bit          got_up;
      bit          got_dn;
      int unsigned t;
      int unsigned h;
      near_up = int'(track_limit);
      near_dn = int'(track_limit);
      idx_up  = 0;
      idx_dn  = 0;
      got_up  = 1'b0;
      got_dn  = 1'b0;
      h       = int'(head);
      for (int i = 0; i < batch_left && i < QUEUE_DEPTH; i++) begin
         t = int'(queue_trk[i]);
         // head already on a requested track: direction left as it is
         if (t == h) return i;
         // only candidates closer than track_count count at all
         if (t > h) begin
            if (t - h < near_up) begin
               near_up = t - h;
               idx_up  = i;
               got_up  = 1'b1;
            end
         end else if (h - t < near_dn) begin
            near_dn = h - t;
            idx_dn  = i;
            got_dn  = 1'b1;
         end
      end
      if (dir_now == DIR_INC) begin
         if (got_up) return idx_up;
         dir_now = DIR_DEC;
         return idx_dn;
      end
      if (dir_now == DIR_DEC) begin
         if (got_dn) return idx_dn;
         dir_now = DIR_INC;
         return idx_up;
      end
      // from idle the nearest wins, the older one on a tie
      if (got_up && (!got_dn || near_up < near_dn ||
                     (near_up == near_dn && idx_up < idx_dn))) begin
         dir_now = DIR_INC;
         return idx_up;
      end
      if (got_dn) begin
         dir_now = DIR_DEC;
         return idx_dn;
      end
      dir_now = DIR_IDLE;
      return 0;
   endfunction

   // applies one command to the predictor state and returns the expected status
   function automatic sched_status_type scheduler_step(input logic [MODE_W-1:0] mode,
                                                       input logic [TRK_W-1:0]  trk);
      sched_status_type s;
      int               idx;
      logic [TRK_W-1:0] t;
      logic [SUM_W-1:0] moved;
      s = '0;
      case (mode)
         MODE_ADD: begin
            if (q_len >= QUEUE_DEPTH || {1'b0, trk} >= track_limit) begin
               s.rejected = 1'b1;
            end else begin
               queue_trk[q_len] = trk;
               q_len++;
            end
         end
         MODE_SERVE: begin
            if (q_len > 0) begin
               // freeze a new batch when the previous one is used up
               if (batch_left == 0) batch_left = q_len;
               idx = choose_entry();
               if (idx >= q_len) idx = 0;
               t = queue_trk[idx];
               moved = (t > head) ? SUM_W'(t - head) : SUM_W'(head - t);
               head = t;
               for (int i = idx; i + 1 < q_len; i++) queue_trk[i] = queue_trk[i + 1];
               q_len--;
               if (batch_left > 0) batch_left--;
               if (traversed > SUM_MAX - moved) traversed = SUM_MAX;
               else traversed = traversed + moved;
               if (served_total != SUM_MAX) served_total = served_total + 1'b1;
               s.served = 1'b1;
               s.seek   = moved[TRK_W-1:0];
            end
         end
         MODE_RESTART: begin
            // queue and open batch survive a restart
            dir_now      = DIR_IDLE;
            head         = trk;
            traversed    = '0;
            served_total = '0;
         end
         default: begin
         end
      endcase
      s.track     = head;
      s.dir       = dir_now;
      s.pending   = PEND_W'(q_len);
      s.traversed = traversed;
      s.count     = served_total;
      return s;
   endfunction

   // idle stretch: mostly none, then mostly short, a few long
   function automatic int idle_len(input int pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 9) == 0) return int'($urandom_range(10, 40));
      return int'($urandom_range(1, 3));
   endfunction

   // track near the head (matches, ties), at the range edges, or anywhere
   function automatic logic [TRK_W-1:0] pick_track();
      int lim;
      int v;
      lim = int'(track_limit);
      case ($urandom_range(0, 9))
         0:       v = int'(head);
         1, 2:    v = int'(head) + int'($urandom_range(0, 6)) - 3;
         3:       v = lim - int'($urandom_range(0, 1));
         4:       v = ($urandom_range(0, 1) != 0) ? 0 : 65535;
         5, 6:    v = int'($urandom_range(0, 65535));
         default: v = int'($urandom_range(0, lim - 1));
      endcase
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return TRK_W'(v);
   endfunction

   task automatic report_mismatch(input string msg);
      err_cnt++;
      if (err_cnt <= MAX_PRINTED) $display("mismatch: %s", msg);
   endtask

   // compares the accepted response with the oldest predicted status
   task automatic check_response();
      sched_status_type e;
      if (status_due.size() == 0) begin
         report_mismatch("response transaction with no command outstanding");
         return;
      end
      e = status_due.pop_front();
      n_checked++;
      if (rsp_served_valid !== e.served)
         report_mismatch($sformatf("rsp %0d served_valid %h want %h",
                                   n_checked, rsp_served_valid, e.served));
      if (rsp_served_track !== e.track)
         report_mismatch($sformatf("rsp %0d served_track %h want %h",
                                   n_checked, rsp_served_track, e.track));
      if (rsp_seek_distance !== e.seek)
         report_mismatch($sformatf("rsp %0d seek_distance %h want %h",
                                   n_checked, rsp_seek_distance, e.seek));
      if (rsp_head_direction !== e.dir)
         report_mismatch($sformatf("rsp %0d head_direction %h want %h",
                                   n_checked, rsp_head_direction, e.dir));
      if (rsp_add_rejected !== e.rejected)
         report_mismatch($sformatf("rsp %0d add_rejected %h want %h",
                                   n_checked, rsp_add_rejected, e.rejected));
      if (rsp_pending_count !== e.pending)
         report_mismatch($sformatf("rsp %0d pending_count %h want %h",
                                   n_checked, rsp_pending_count, e.pending));
      if (rsp_total_traversed !== e.traversed)
         report_mismatch($sformatf("rsp %0d total_traversed %h want %h",
                                   n_checked, rsp_total_traversed, e.traversed));
      if (rsp_served_count !== e.count)
         report_mismatch($sformatf("rsp %0d served_count %h want %h",
                                   n_checked, rsp_served_count, e.count));
   endtask

   // offers one command, predicts on acceptance, then maybe idles
   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [TRK_W-1:0] trk,
                            input bit use_typed, input sched_status_type typed);
      sched_status_type s;
      int               g;
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_request_track <= trk;
      do @(posedge clock); while (req_stall);
      s = scheduler_step(mode, trk);
      status_due.insert(status_due.size(), use_typed ? typed : s);
      if (mode != MODE_UNUSED) n_items++;
      n_rejects += int'(s.rejected);
      n_serves  += int'(s.served);
      g = idle_len(gap_pct);
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // sender holds off until every outstanding response has been checked
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (status_due.size() != 0);
   endtask

   task automatic write_track_count(input logic [TC_W-1:0] v);
      drain_results();
      repeat (4) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_track_count <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      track_limit = v;
      n_csr++;
   endtask

   // random traffic under one track_count: mostly add bursts followed by serves
   task automatic run_phase(input logic [TC_W-1:0] tc, input int items,
                            input int gpct, input int spct, input bit pressure);
      int start;
      int k;
      bit held;
      bit paused;
      write_track_count(tc);
      gap_pct   = gpct;
      stall_pct = spct;
      start     = n_items;
      held      = 1'b0;
      paused    = 1'b0;
      while (n_items - start < items) begin
         if (pressure && !held && n_items - start >= items / 2) begin
            // long receiver hold-off while commands keep coming
            hold_req = HOLD_CYCLES;
            held     = 1'b1;
         end
         if (pressure && !paused && n_items - start >= 3 * items / 4) begin
            drain_results();
            paused = 1'b1;
         end
         case ($urandom_range(0, 19))
            0: send_item(MODE_RESTART, TRK_W'($urandom_range(0, 65535)), 1'b0, '0);
            1: send_item(MODE_UNUSED, TRK_W'($urandom_range(0, 65535)), 1'b0, '0);
            2: begin
               // overfill the queue
               repeat (QUEUE_DEPTH + 2) send_item(MODE_ADD, pick_track(), 1'b0, '0);
            end
            default: begin
               k = ($urandom_range(0, 7) == 0) ? int'($urandom_range(7, QUEUE_DEPTH))
                                               : int'($urandom_range(1, 5));
               repeat (k) begin
                  send_item(MODE_ADD, pick_track(), 1'b0, '0);
                  if ($urandom_range(0, 5) == 0)
                     send_item(MODE_SERVE, TRK_W'($urandom_range(0, 65535)), 1'b0, '0);
               end
               repeat ($urandom_range(1, k + 1))
                  send_item(MODE_SERVE, TRK_W'($urandom_range(0, 65535)), 1'b0, '0);
            end
         endcase
      end
   endtask

   // response side: check accepted transactions and drive rsp_stall
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) check_response();
         if (hold_req > 0) begin
            stall_left = hold_req;
            hold_req   = 0;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            stall_left = idle_len(stall_pct);
            rsp_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   // watchdog: any channel handshake restarts the count
   initial begin
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      q_len        = 0;
      batch_left   = 0;
      head         = '0;
      dir_now      = DIR_IDLE;
      traversed    = '0;
      served_total = '0;
      track_limit  = TRACK_COUNT_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part
      gap_pct   = 30;
      stall_pct = 30;
      foreach (PLAN[i]) begin
         if (PLAN[i].kind == ROW_CSR)
            write_track_count(PLAN[i].value);
         else
            send_item(PLAN[i].mode, PLAN[i].value[TRK_W-1:0],
                      PLAN[i].kind == ROW_TYPED, PLAN[i].want);
      end

      // random part over several disk sizes, extremes included
      run_phase(TRACK_COUNT_RESET, 200, 30, 30, 1'b1);
      run_phase(17'd1, 100, 20, 20, 1'b0);
      run_phase(17'd300, 150, 0, 0, 1'b0);
      run_phase(TC_W'($urandom_range(2, 65535)), 200, 40, 40, 1'b0);
      run_phase(17'd16, 150, 25, 50, 1'b0);
      run_phase(17'd65535, 225, 10, 10, 1'b0);

      // bounce between the track extremes for a run of full-stroke seeks
      write_track_count(TRACK_COUNT_RESET);
      gap_pct   = 0;
      stall_pct = 0;
      send_item(MODE_RESTART, '0, 1'b0, '0);
      repeat (10) begin
         send_item(MODE_ADD, (head == '0) ? TRK_W'(65535) : TRK_W'(0), 1'b0, '0);
         send_item(MODE_SERVE, TRK_W'($urandom_range(0, 65535)), 1'b0, '0);
      end

      drain_results();
      repeat (60) @(posedge clock);
      $display("summary: %0d commands, %0d serves, %0d refused adds, %0d responses checked",
               n_items, n_serves, n_rejects, n_checked);
      $display("summary: %0d track_count writes, directed table, six random phases, %s",
               n_csr, "full-stroke seeks back to back");
      if (err_cnt == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", err_cnt);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
